// ===== rtl/rfbf_pkg.sv =====
package rfbf_pkg;

    localparam int ROW_LEN      = 64;
    localparam int COL_W        = 6;
    localparam int TWIDDLE_BITS = 18;
    localparam int GUARD        = 12;
    localparam int MAX_WAVE     = (ROW_LEN + 1) / 2;
    localparam int NWAVE        = MAX_WAVE + 1;
    localparam int WAVE_W       = 6;
    localparam int SAMPLE_W     = 32;
    localparam int COEF_W       = 48;
    localparam int TW_W         = TWIDDLE_BITS + 2;
    localparam int PROD_W       = COEF_W + TW_W;
    localparam int ACC_W        = 58;
    localparam int CFG_W        = 6;

    localparam logic REG_FIRST_WAVE = 1'b0;
    localparam logic REG_LAST_WAVE  = 1'b1;

    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30    = 64'd1 << 30;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_AN_ISSUE,
        ST_AN_DRAIN,
        ST_AN_WRITE,
        ST_RB_START,
        ST_RB_ISSUE,
        ST_RB_DRAIN,
        ST_RB_LOAD,
        ST_PASS_RD,
        ST_PASS_LOAD,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic valid;
        logic rnd;
        logic acc_sin;
        logic use_sin;
    } mac_op_t;

    typedef logic signed [TW_W-1:0] tw_table_t [ROW_LEN];

    // shift and subtract quotient, table build only
    function automatic longint unsigned long_div(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // quarter-wave taylor series, rotated by quadrant
    function automatic tw_table_t build_table(input bit want_sin);
        tw_table_t tab;
        longint unsigned t;
        longint unsigned q;
        longint unsigned u;
        longint unsigned phi;
        longint unsigned term;
        longint signed c;
        longint signed s;
        longint signed cr;
        longint signed sr;
        longint signed vc;
        longint signed vs;
        for (int r = 0; r < ROW_LEN; r++)
        begin
            t = 4 * r;
            q = t / ROW_LEN;
            u = t - q * ROW_LEN;
            phi = (HALFPI_Q30 * u + ROW_LEN / 2) / ROW_LEN;
            term = ONE_Q30;
            c = ONE_Q30;
            s = 0;
            for (int k = 1; k <= 20; k++)
            begin
                term = (term * phi + (64'd1 << 29)) >> 30;
                term = long_div(term + longint'(k / 2), longint'(k));
                case (k % 4)
                    1: s = s + longint'(term);
                    2: c = c - longint'(term);
                    3: s = s - longint'(term);
                    default: c = c + longint'(term);
                endcase
            end
            if (c < 0) c = 0;
            if (c > longint'(ONE_Q30)) c = ONE_Q30;
            if (s < 0) s = 0;
            if (s > longint'(ONE_Q30)) s = ONE_Q30;
            cr = (c + (64'sd1 << (29 - TWIDDLE_BITS))) >>> (30 - TWIDDLE_BITS);
            sr = (s + (64'sd1 << (29 - TWIDDLE_BITS))) >>> (30 - TWIDDLE_BITS);
            case (q % 4)
                0: begin vc = cr;  vs = sr;  end
                1: begin vc = -sr; vs = cr;  end
                2: begin vc = -cr; vs = -sr; end
                default: begin vc = sr; vs = -cr; end
            endcase
            tab[r] = want_sin ? TW_W'(vs) : TW_W'(vc);
        end
        return tab;
    endfunction

    localparam tw_table_t TW_COS = build_table(1'b0);
    localparam tw_table_t TW_SIN = build_table(1'b1);

endpackage

// ===== rtl/row_fourier_band_filter.sv =====
// after the last sample of a row, all 33 waves are analysed before its first result,
// then each column is rebuilt from the waves of its band; no new row is taken until
// every result of the last one has been sent. Throughput is set by the single shared
// multiply-accumulate unit doing one product a cycle
// a row with a missing sample or bad wave range skips the math
// reset: async active low, clears fill count, missing flag and control; wave range to 0..32
module row_fourier_band_filter
    import rfbf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       missing,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic [COL_W-1:0]           column,
    output logic                       last,
    output logic [1:0]                 status
);

    state_t                    state_reg, state_next;
    logic [COL_W-1:0]          fill_reg, fill_next;
    logic                      missing_reg, missing_next;
    logic [WAVE_W-1:0]         first_wave_reg;
    logic [WAVE_W-1:0]         last_wave_reg;
    status_t                   status_reg, status_next;
    logic [WAVE_W-1:0]         wave_reg, wave_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [COL_W-1:0]          m_reg, m_next;
    logic                      phase_reg, phase_next;
    logic [1:0]                drain_reg, drain_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    mac_op_t                   op_reg, op_next;
    logic signed [TW_W-1:0]    tw_reg;

    logic                      in_xfer;
    logic                      out_xfer;
    logic                      coef_we;
    logic                      mac_clear;
    logic [SAMPLE_W-1:0]       row_q;
    logic [2*COEF_W-1:0]       coef_q;
    logic [2*COEF_W-1:0]       coef_wdata;
    logic signed [COEF_W-1:0]  mac_a;
    logic signed [ACC_W-1:0]   acc_cos;
    logic signed [ACC_W-1:0]   acc_sin;
    logic [2*COL_W-1:0]        start_prod;
    logic [ACC_W-1:0]          rb_mag;
    logic [ACC_W-1:0]          rb_rnd;
    logic signed [SAMPLE_W-1:0] rb_result;

    function automatic logic signed [COEF_W-1:0] coef_round(
        input logic signed [ACC_W-1:0] v,
        input logic                    wave0
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        if (wave0)
        begin
            r = (mag + (ACC_W'(1) << (GUARD - 1))) >> GUARD;
        end
        else
        begin
            r = (mag + (ACC_W'(1) << (GUARD - 2))) >> (GUARD - 1);
        end
        return v[ACC_W-1] ? -COEF_W'(r) : COEF_W'(r);
    endfunction

    assign in_stall = (state_reg != ST_FILL);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    rfbf_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROW_LEN)) u_row_ram (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (fill_reg),
        .wdata (sample_in),
        .raddr (col_reg),
        .rdata (row_q)
    );

    assign coef_wdata = {coef_round(acc_sin, wave_reg == '0),
                         coef_round(acc_cos, wave_reg == '0)};

    rfbf_ram #(.WIDTH(2 * COEF_W), .DEPTH(NWAVE)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (wave_reg),
        .wdata (coef_wdata),
        .raddr (wave_reg),
        .rdata (coef_q)
    );

    always_comb
    begin
        if (op_reg.rnd)
        begin
            mac_a = op_reg.use_sin ? coef_q[2*COEF_W-1:COEF_W] : coef_q[COEF_W-1:0];
        end
        else
        begin
            mac_a = {{(COEF_W - SAMPLE_W){row_q[SAMPLE_W-1]}}, row_q};
        end
    end

    rfbf_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op_reg),
        .a       (mac_a),
        .c       (tw_reg),
        .clear   (mac_clear),
        .acc_cos (acc_cos),
        .acc_sin (acc_sin)
    );

    // rebuilt sample: round to whole units and saturate
    always_comb
    begin
        rb_mag = acc_cos[ACC_W-1] ? ACC_W'(-acc_cos) : ACC_W'(acc_cos);
        rb_rnd = (rb_mag + (ACC_W'(1) << (GUARD - 1))) >> GUARD;
        if (!acc_cos[ACC_W-1])
        begin
            if (rb_rnd > ACC_W'(64'h7fff_ffff))
                rb_result = {1'b0, {(SAMPLE_W - 1){1'b1}}};
            else
                rb_result = rb_rnd[SAMPLE_W-1:0];
        end
        else
        begin
            if (rb_rnd > ACC_W'(64'h8000_0000))
                rb_result = {1'b1, {(SAMPLE_W - 1){1'b0}}};
            else
                rb_result = -rb_rnd[SAMPLE_W-1:0];
        end
    end

    assign start_prod = first_wave_reg * col_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        missing_next    = missing_reg;
        status_next     = status_reg;
        wave_next       = wave_reg;
        col_next        = col_reg;
        m_next          = m_reg;
        phase_next      = phase_reg;
        drain_next      = drain_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        op_next         = '0;
        coef_we         = 1'b0;
        mac_clear       = 1'b0;

        case (state_reg)
            ST_FILL:
            begin
                if (in_xfer)
                begin
                    fill_next    = fill_reg + 1'b1;
                    missing_next = missing_reg | missing;
                    if (fill_reg == COL_W'(ROW_LEN - 1))
                    begin
                        fill_next    = '0;
                        missing_next = 1'b0;
                        col_next     = '0;
                        wave_next    = '0;
                        m_next       = '0;
                        phase_next   = 1'b0;
                        if (missing_reg || missing)
                        begin
                            status_next = STAT_MISSING;
                            state_next  = ST_PASS_RD;
                        end
                        else if (first_wave_reg > WAVE_W'(MAX_WAVE) ||
                                 last_wave_reg > WAVE_W'(MAX_WAVE))
                        begin
                            status_next = STAT_RANGE;
                            state_next  = ST_PASS_RD;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                            state_next  = ST_AN_ISSUE;
                        end
                    end
                end
            end

            ST_AN_ISSUE:
            begin
                op_next.valid   = 1'b1;
                op_next.acc_sin = phase_reg;
                op_next.use_sin = phase_reg;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    m_next     = m_reg + wave_reg[COL_W-1:0];
                    if (col_reg == COL_W'(ROW_LEN - 1))
                    begin
                        col_next   = '0;
                        drain_next = '0;
                        state_next = ST_AN_DRAIN;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end

            ST_AN_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                    state_next = ST_AN_WRITE;
            end

            ST_AN_WRITE:
            begin
                coef_we   = 1'b1;
                mac_clear = 1'b1;
                m_next    = '0;
                if (wave_reg == WAVE_W'(MAX_WAVE))
                begin
                    col_next   = '0;
                    state_next = ST_RB_START;
                end
                else
                begin
                    wave_next  = wave_reg + 1'b1;
                    state_next = ST_AN_ISSUE;
                end
            end

            ST_RB_START:
            begin
                wave_next  = first_wave_reg;
                m_next     = start_prod[COL_W-1:0];
                phase_next = 1'b0;
                drain_next = '0;
                if (last_wave_reg < first_wave_reg)
                    state_next = ST_RB_DRAIN;
                else
                    state_next = ST_RB_ISSUE;
            end

            ST_RB_ISSUE:
            begin
                op_next.valid   = 1'b1;
                op_next.rnd     = 1'b1;
                op_next.use_sin = phase_reg;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    if (wave_reg == last_wave_reg)
                    begin
                        drain_next = '0;
                        state_next = ST_RB_DRAIN;
                    end
                    else
                    begin
                        wave_next = wave_reg + 1'b1;
                        m_next    = m_reg + col_reg;
                    end
                end
            end

            ST_RB_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                    state_next = ST_RB_LOAD;
            end

            ST_RB_LOAD:
            begin
                mac_clear       = 1'b1;
                sample_out_next = rb_result;
                out_valid_next  = 1'b1;
                state_next      = ST_WAIT;
            end

            ST_PASS_RD:
            begin
                state_next = ST_PASS_LOAD;
            end

            ST_PASS_LOAD:
            begin
                sample_out_next = row_q;
                out_valid_next  = 1'b1;
                state_next      = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    if (col_reg == COL_W'(ROW_LEN - 1))
                    begin
                        col_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = (status_reg == STAT_OK) ? ST_RB_START : ST_PASS_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            fill_reg       <= '0;
            missing_reg    <= 1'b0;
            first_wave_reg <= '0;
            last_wave_reg  <= WAVE_W'(32);
            status_reg     <= STAT_OK;
            wave_reg       <= '0;
            col_reg        <= '0;
            m_reg          <= '0;
            phase_reg      <= 1'b0;
            drain_reg      <= '0;
            out_valid_reg  <= 1'b0;
            op_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            missing_reg   <= missing_next;
            status_reg    <= status_next;
            wave_reg      <= wave_next;
            col_reg       <= col_next;
            m_reg         <= m_next;
            phase_reg     <= phase_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_FIRST_WAVE)
                    first_wave_reg <= cfg_data;
                else if (cfg_index == REG_LAST_WAVE)
                    last_wave_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_out_reg <= sample_out_next;
        tw_reg         <= phase_reg ? TW_SIN[m_reg] : TW_COS[m_reg];
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign column     = col_reg;
    assign last       = (col_reg == COL_W'(ROW_LEN - 1));
    assign status     = status_reg;

    a_out_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_WAIT)
        else $error("result shown outside the wait state");

    a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && col_reg == COL_W'(ROW_LEN - 1)) |=>
            (state_reg == ST_FILL && fill_reg == '0 && !missing_reg))
        else $error("row not closed after its final transfer");

    a_rebuild_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RB_LOAD || state_reg == ST_AN_WRITE) |-> status_reg == STAT_OK)
        else $error("filter math on a row that should pass unchanged");

endmodule

// ===== rtl/rfbf_ram.sv =====
module rfbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rfbf_mac.sv =====
module rfbf_mac
    import rfbf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_op_t                  op,
    input  logic signed [COEF_W-1:0] a,
    input  logic signed [TW_W-1:0]   c,
    input  logic                     clear,
    output logic signed [ACC_W-1:0]  acc_cos,
    output logic signed [ACC_W-1:0]  acc_sin
);

    mac_op_t                   op1_reg;
    mac_op_t                   op2_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic signed [ACC_W-1:0]   term_reg;
    logic signed [ACC_W-1:0]   term_next;
    logic signed [ACC_W-1:0]   acc_cos_reg;
    logic signed [ACC_W-1:0]   acc_sin_reg;
    logic [PROD_W-1:0]         p_mag;
    logic [PROD_W-1:0]         p_rnd;

    // product rounded half away from zero to coefficient units on rnd ops, else passed unrounded
    always_comb
    begin
        p_mag = p_reg[PROD_W-1] ? PROD_W'(-p_reg) : PROD_W'(p_reg);
        p_rnd = (p_mag + (PROD_W'(1) << (TWIDDLE_BITS - 1))) >> TWIDDLE_BITS;
        if (op1_reg.rnd)
        begin
            term_next = p_reg[PROD_W-1] ? -ACC_W'(p_rnd) : ACC_W'(p_rnd);
        end
        else
        begin
            term_next = ACC_W'(p_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg     <= '0;
            op2_reg     <= '0;
            acc_cos_reg <= '0;
            acc_sin_reg <= '0;
        end
        else
        begin
            op1_reg <= op;
            op2_reg <= op1_reg;
            if (clear)
            begin
                acc_cos_reg <= '0;
                acc_sin_reg <= '0;
            end
            else if (op2_reg.valid)
            begin
                if (op2_reg.acc_sin)
                begin
                    acc_sin_reg <= acc_sin_reg + term_reg;
                end
                else
                begin
                    acc_cos_reg <= acc_cos_reg + term_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= PROD_W'(a) * PROD_W'(c);
        term_reg <= term_next;
    end

    assign acc_cos = acc_cos_reg;
    assign acc_sin = acc_sin_reg;

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clear |-> (!op1_reg.valid && !op2_reg.valid && !op.valid))
        else $error("accumulator cleared with products in flight");

endmodule
